>>> rtl/csrp_pkg.sv
// Shared types and constants for the contact score rectangle packer.
// No dependencies; imported by the top level.
`default_nettype none

package csrp_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ORIENT,
        ST_RD,
        ST_CNT,
        ST_CMP,
        ST_LRD,
        ST_LCHK,
        ST_PRD,
        ST_PWR,
        ST_DONE
    } state_t;

    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned SCORE_W = 9;

    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_PLACE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/csrp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the right, left, up and down edge bitmaps.
`default_nettype none

module csrp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/contact_score_rect_packer.sv
// Contact score rectangle packer: top level with control sequencer and scoring.
// Depends on csrp_pkg and csrp_ram.
// Flow: a place item is accepted in ST_IDLE and each orientation is set up in ST_ORIENT.
// Each scanned position then passes ST_RD, ST_CNT and ST_CMP, each line of the legality
// check ST_LRD and ST_LCHK; ST_PRD and ST_PWR write the edges, ST_DONE loads the result.
// One item is in work at a time. A clear item or a register write sweeps the bitmaps.
// After reset the same sweep runs with s_tready low; the canvas is 64 by 64.
`default_nettype none

module contact_score_rect_packer #(
    parameter int unsigned MAX_CANVAS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // rect_width, rect_height, try_rotation, zero pad
    input  wire logic        s_tuser,  // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,  // pos_x, pos_y, rotated_flag, contact_score, zero pad
    output logic             m_tuser   // placed
);

    import csrp_pkg::*;

    localparam int unsigned LW    = $clog2(MAX_CANVAS + 1);
    localparam int unsigned DEPTH = MAX_CANVAS + 1;
    localparam int unsigned EW    = (LW > SIZE_W) ? LW + 1 : SIZE_W + 1;
    localparam int unsigned SCW   = LW + 2;

    function automatic logic [MAX_CANVAS-1:0] mask_fn(input logic [LW-1:0] lo,
                                                      input logic [LW-1:0] n);
        logic [MAX_CANVAS:0] one_hot;
        logic [MAX_CANVAS:0] ones;
        one_hot = (MAX_CANVAS + 1)'(1) << n;
        ones    = one_hot - (MAX_CANVAS + 1)'(1);
        return ones[MAX_CANVAS-1:0] << lo;
    endfunction

    function automatic logic [LW-1:0] eff_fn(input logic [CFG_W-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        if (e == '0)
        begin
            e = EW'(1);
        end
        else if (e > EW'(MAX_CANVAS))
        begin
            e = EW'(MAX_CANVAS);
        end
        return e[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] pop_fn(input logic [MAX_CANVAS-1:0] v);
        logic [LW-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_CANVAS; i++)
        begin
            c = c + LW'(v[i]);
        end
        return c;
    endfunction

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_w_reg, cfg_h_reg;
    logic [LW-1:0]     clr_idx_reg;
    logic              clr_pend_reg;
    logic              m_tvalid_reg;

    logic [SIZE_W-1:0] iw_reg, ih_reg;
    logic              irot_reg;
    logic              orient_reg, pass_reg, pstep_reg;
    logic [LW-1:0]     x_reg, y_reg, cw_reg, ch_reg, k_reg;
    logic [LW:0]       side_reg, tb_reg;
    logic [SCW-1:0]    best_reg;
    logic [LW-1:0]     bx_reg, by_reg;
    logic              brot_reg;
    logic              out_placed_reg, out_rot_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg;
    logic [SCORE_W-1:0] out_score_reg;

    logic              cfg_wr, accept, load_out;
    logic [LW-1:0]     eff_w, eff_h;
    logic [SIZE_W-1:0] ow, oh;
    logic              fit, more_orient;
    logic [LW-1:0]     bw, bh, kmax;
    logic              in_last, out_last, scan_end;
    logic              cand, need_chk, bad, last_k, take, adv, best_nz;
    logic [SCW-1:0]    score;
    logic              in_place;
    logic [LW-1:0]     mlo_x, mn_x, mlo_y, mn_y;
    logic [MAX_CANVAS-1:0] mask_x, mask_y, wall_w, wall_h;
    logic [LW-1:0]     r_addr, l_addr, u_addr, d_addr;
    logic              mem_we;
    logic [MAX_CANVAS-1:0] r_wdata, l_wdata, u_wdata, d_wdata;
    logic [MAX_CANVAS-1:0] r_q, l_q, u_q, d_q;
    state_t            orient_end;

    assign cfg_wr   = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CANVAS_HEIGHT) ? 32'(cfg_h_reg) : 32'(cfg_w_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign load_out = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_placed_reg;
    assign m_tdata  = {2'b00, out_score_reg, out_rot_reg, out_y_reg, out_x_reg};

    assign eff_w = eff_fn(cfg_w_reg);
    assign eff_h = eff_fn(cfg_h_reg);

    assign ow  = orient_reg ? ih_reg : iw_reg;
    assign oh  = orient_reg ? iw_reg : ih_reg;
    assign fit = (ow != '0) && (oh != '0) && (EW'(ow) <= EW'(eff_w)) && (EW'(oh) <= EW'(eff_h));
    assign more_orient = !orient_reg && irot_reg && (iw_reg != ih_reg);

    assign bw   = LW'(brot_reg ? ih_reg : iw_reg);
    assign bh   = LW'(brot_reg ? iw_reg : ih_reg);
    assign kmax = (cw_reg > ch_reg) ? cw_reg : ch_reg;

    assign in_last  = pass_reg ? (x_reg == eff_w - cw_reg) : (y_reg == eff_h - ch_reg);
    assign out_last = pass_reg ? (y_reg == eff_h - ch_reg) : (x_reg == eff_w - cw_reg);
    assign scan_end = pass_reg && in_last && out_last;

    assign in_place = (state_reg == ST_PRD) || (state_reg == ST_PWR);
    assign mlo_x  = in_place ? bx_reg : x_reg;
    assign mn_x   = in_place ? bw : cw_reg;
    assign mlo_y  = in_place ? by_reg : y_reg;
    assign mn_y   = in_place ? bh : ch_reg;
    assign mask_x = mask_fn(mlo_x, mn_x);
    assign mask_y = mask_fn(mlo_y, mn_y);
    assign wall_w = mask_fn('0, eff_w);
    assign wall_h = mask_fn('0, eff_h);

    assign score    = SCW'(side_reg) + SCW'(tb_reg);
    assign need_chk = kmax > LW'(1);
    assign cand     = (pass_reg ? (tb_reg != '0) : (side_reg != '0)) && (score > best_reg);
    assign bad      = ((k_reg < cw_reg) && (((r_q | l_q) & mask_y) != '0)) ||
                      ((k_reg < ch_reg) && (((u_q | d_q) & mask_x) != '0));
    assign last_k   = (k_reg + LW'(1)) == kmax;
    assign take     = ((state_reg == ST_CMP) && cand && !need_chk) ||
                      ((state_reg == ST_LCHK) && !bad && last_k);
    assign adv      = ((state_reg == ST_CMP) && (!cand || !need_chk)) ||
                      ((state_reg == ST_LCHK) && (bad || last_k));
    assign best_nz  = (best_reg != '0) || take;

    always_comb
    begin
        if (more_orient)
        begin
            orient_end = ST_ORIENT;
        end
        else if (best_nz)
        begin
            orient_end = ST_PRD;
        end
        else
        begin
            orient_end = ST_DONE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_idx_reg == LW'(MAX_CANVAS))
                    begin
                        state_next = clr_pend_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_next = (s_tuser == OP_CLEAR) ? ST_CLEAR : ST_ORIENT;
                    end
                end
                ST_ORIENT: state_next = fit ? ST_RD : orient_end;
                ST_RD:     state_next = ST_CNT;
                ST_CNT:    state_next = ST_CMP;
                ST_CMP:
                begin
                    if (cand && need_chk)
                    begin
                        state_next = ST_LRD;
                    end
                    else
                    begin
                        state_next = scan_end ? orient_end : ST_RD;
                    end
                end
                ST_LRD:    state_next = ST_LCHK;
                ST_LCHK:
                begin
                    if (bad || last_k)
                    begin
                        state_next = scan_end ? orient_end : ST_RD;
                    end
                    else
                    begin
                        state_next = ST_LRD;
                    end
                end
                ST_PRD:    state_next = ST_PWR;
                ST_PWR:    state_next = pstep_reg ? ST_DONE : ST_PRD;
                ST_DONE:   state_next = load_out ? ST_IDLE : ST_DONE;
                default:   state_next = ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        r_addr  = '0;
        l_addr  = '0;
        u_addr  = '0;
        d_addr  = '0;
        mem_we  = 1'b0;
        r_wdata = '0;
        l_wdata = '0;
        u_wdata = '0;
        d_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                r_addr  = clr_idx_reg;
                l_addr  = clr_idx_reg;
                u_addr  = clr_idx_reg;
                d_addr  = clr_idx_reg;
                mem_we  = 1'b1;
                r_wdata = (clr_idx_reg == '0) ? wall_h : '0;
                l_wdata = (clr_idx_reg == eff_w) ? wall_h : '0;
                u_wdata = (clr_idx_reg == '0) ? wall_w : '0;
                d_wdata = (clr_idx_reg == eff_h) ? wall_w : '0;
            end
            ST_RD:
            begin
                r_addr = x_reg;
                l_addr = x_reg + cw_reg;
                u_addr = y_reg;
                d_addr = y_reg + ch_reg;
            end
            ST_LRD:
            begin
                r_addr = (k_reg < cw_reg) ? x_reg + k_reg : x_reg;
                l_addr = r_addr;
                u_addr = (k_reg < ch_reg) ? y_reg + k_reg : y_reg;
                d_addr = u_addr;
            end
            ST_PRD, ST_PWR:
            begin
                r_addr = pstep_reg ? bx_reg : bx_reg + bw;
                l_addr = r_addr;
                u_addr = pstep_reg ? by_reg : by_reg + bh;
                d_addr = u_addr;
                mem_we = (state_reg == ST_PWR);
                if (!pstep_reg)
                begin
                    r_wdata = r_q | (mask_y & ~l_q);
                    l_wdata = l_q & ~mask_y;
                    u_wdata = u_q | (mask_x & ~d_q);
                    d_wdata = d_q & ~mask_x;
                end
                else
                begin
                    l_wdata = l_q | (mask_y & ~r_q);
                    r_wdata = r_q & ~mask_y;
                    d_wdata = d_q | (mask_x & ~u_q);
                    u_wdata = u_q & ~mask_x;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    csrp_ram #(.WIDTH(MAX_CANVAS), .DEPTH(DEPTH)) u_right_ram (
        .clk(clk), .we(mem_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_q)
    );
    csrp_ram #(.WIDTH(MAX_CANVAS), .DEPTH(DEPTH)) u_left_ram (
        .clk(clk), .we(mem_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_q)
    );
    csrp_ram #(.WIDTH(MAX_CANVAS), .DEPTH(DEPTH)) u_up_ram (
        .clk(clk), .we(mem_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_q)
    );
    csrp_ram #(.WIDTH(MAX_CANVAS), .DEPTH(DEPTH)) u_down_ram (
        .clk(clk), .we(mem_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cfg_w_reg    <= 7'd64;
            cfg_h_reg    <= 7'd64;
            clr_idx_reg  <= '0;
            clr_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_CANVAS_HEIGHT)
                begin
                    cfg_h_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    cfg_w_reg <= pwdata[CFG_W-1:0];
                end
            end
            if (cfg_wr || accept)
            begin
                clr_idx_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + LW'(1);
            end
            if (cfg_wr)
            begin
                clr_pend_reg <= 1'b0;
            end
            else if (accept)
            begin
                clr_pend_reg <= (s_tuser == OP_CLEAR);
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iw_reg     <= s_tdata[6:0];
            ih_reg     <= s_tdata[13:7];
            irot_reg   <= s_tdata[14];
            orient_reg <= 1'b0;
            pstep_reg  <= 1'b0;
            best_reg   <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
            brot_reg   <= 1'b0;
        end
        if (state_reg == ST_ORIENT)
        begin
            cw_reg   <= LW'(ow);
            ch_reg   <= LW'(oh);
            pass_reg <= 1'b0;
            x_reg    <= '0;
            y_reg    <= '0;
            if (!fit)
            begin
                orient_reg <= 1'b1;
            end
        end
        if (state_reg == ST_CNT)
        begin
            side_reg <= {1'b0, pop_fn(r_q & mask_y)} + {1'b0, pop_fn(l_q & mask_y)};
            tb_reg   <= {1'b0, pop_fn(u_q & mask_x)} + {1'b0, pop_fn(d_q & mask_x)};
        end
        if (state_reg == ST_CMP)
        begin
            k_reg <= LW'(1);
        end
        else if ((state_reg == ST_LCHK) && !bad && !last_k)
        begin
            k_reg <= k_reg + LW'(1);
        end
        if (take)
        begin
            best_reg <= score;
            bx_reg   <= x_reg;
            by_reg   <= y_reg;
            brot_reg <= orient_reg;
        end
        if (adv)
        begin
            if (scan_end)
            begin
                orient_reg <= 1'b1;
            end
            else if (!pass_reg)
            begin
                if (!in_last)
                begin
                    y_reg <= y_reg + LW'(1);
                end
                else
                begin
                    y_reg <= '0;
                    if (out_last)
                    begin
                        pass_reg <= 1'b1;
                        x_reg    <= '0;
                    end
                    else
                    begin
                        x_reg <= x_reg + LW'(1);
                    end
                end
            end
            else
            begin
                if (!in_last)
                begin
                    x_reg <= x_reg + LW'(1);
                end
                else
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + LW'(1);
                end
            end
        end
        if (state_reg == ST_PWR)
        begin
            pstep_reg <= 1'b1;
        end
        if (load_out)
        begin
            out_placed_reg <= (best_reg != '0);
            out_x_reg      <= POS_W'(bx_reg);
            out_y_reg      <= POS_W'(by_reg);
            out_rot_reg    <= brot_reg;
            out_score_reg  <= SCORE_W'(best_reg);
        end
    end

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("edge memory written while idle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("unplaced item carries nonzero payload");

    a_placed_score: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[21:13] != '0))
        else $error("placed item with zero contact");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LCHK) |-> ((k_reg != '0) && (k_reg < kmax)))
        else $error("legality line index out of range");

    a_take_best: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (best_reg != '0))
        else $error("best score lost after update");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for contact_score_rect_packer: directed, random and back-pressure tests.
// Holds its own edge-bitmap model of the packer and checks every result item against it.
// Depends on csrp_pkg and the RTL of the packer.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csrp_pkg::*;

    localparam int CANVAS_MAX = 64;
    localparam int SWEEP_WAIT = CANVAS_MAX + 10;
    localparam int CYCLE_LIMIT = 4000000;

    typedef enum int {EDGE_RIGHT = 0, EDGE_LEFT = 1, EDGE_UP = 2, EDGE_DOWN = 3} edge_dir_t;

    typedef struct packed {
        logic                 placed;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic                 rotated;
        logic [SCORE_W-1:0]   score;
    } placement_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    contact_score_rect_packer #(.MAX_CANVAS(CANVAS_MAX)) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [CFG_W-1:0] canvas_w_reg = 7'd64;
    logic [CFG_W-1:0] canvas_h_reg = 7'd64;
    logic [63:0]      edge_map [0:3][0:CANVAS_MAX];
    placement_t       pending_placements [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               rx_hold = 0;
    int               rx_wait = 0;

    function automatic int eff_size(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > CANVAS_MAX)
            return CANVAS_MAX;
        return int'(v);
    endfunction

    function automatic int edge_count(int d, int line, int lo, int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++)
            c += edge_map[d][line][(lo + i) & 63];
        return c;
    endfunction

    function automatic void add_edges(int d, int line, int lo, int n);
        int b;
        for (int i = 0; i < n; i++)
        begin
            b = (lo + i) & 63;
            if (edge_map[d ^ 1][line][b])
                edge_map[d ^ 1][line][b] = 1'b0;
            else
                edge_map[d][line][b] = 1'b1;
        end
    endfunction

    function automatic void build_walls();
        int cw;
        int ch;
        cw = eff_size(canvas_w_reg);
        ch = eff_size(canvas_h_reg);
        for (int d = 0; d < 4; d++)
            for (int l = 0; l <= CANVAS_MAX; l++)
                edge_map[d][l] = '0;
        add_edges(EDGE_RIGHT, 0, 0, ch);
        add_edges(EDGE_LEFT, cw, 0, ch);
        add_edges(EDGE_UP, 0, 0, cw);
        add_edges(EDGE_DOWN, ch, 0, cw);
    endfunction

    function automatic bit is_free(int x, int y, int w, int h);
        for (int i = x + 1; i < x + w; i++)
            if (edge_count(EDGE_RIGHT, i, y, h) != 0 || edge_count(EDGE_LEFT, i, y, h) != 0)
                return 1'b0;
        for (int i = y + 1; i < y + h; i++)
            if (edge_count(EDGE_UP, i, x, w) != 0 || edge_count(EDGE_DOWN, i, x, w) != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int best_spot(int w, int h, output int bx, output int by);
        int cw;
        int ch;
        int best;
        int x;
        int y;
        int side;
        int tb_cnt;
        int outer_n;
        int inner_n;
        cw = eff_size(canvas_w_reg);
        ch = eff_size(canvas_h_reg);
        best = 0;
        bx = 0;
        by = 0;
        if (w == 0 || h == 0 || w > cw || h > ch)
            return 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            outer_n = pass == 0 ? cw - w : ch - h;
            inner_n = pass == 0 ? ch - h : cw - w;
            for (int a = 0; a <= outer_n; a++)
                for (int b = 0; b <= inner_n; b++)
                begin
                    x = pass == 0 ? a : b;
                    y = pass == 0 ? b : a;
                    side = edge_count(EDGE_RIGHT, x, y, h) + edge_count(EDGE_LEFT, x + w, y, h);
                    tb_cnt = edge_count(EDGE_UP, y, x, w) + edge_count(EDGE_DOWN, y + h, x, w);
                    if (pass == 0 ? side == 0 : tb_cnt == 0)
                        continue;
                    if (side + tb_cnt > best && is_free(x, y, w, h))
                    begin
                        best = side + tb_cnt;
                        bx = x;
                        by = y;
                    end
                end
        end
        return best;
    endfunction

    function automatic void mark_rect(int x, int y, int w, int h);
        add_edges(EDGE_RIGHT, x + w, y, h);
        add_edges(EDGE_LEFT, x, y, h);
        add_edges(EDGE_UP, y + h, x, w);
        add_edges(EDGE_DOWN, y, x, w);
    endfunction

    function automatic placement_t best_placement(logic op, logic [SIZE_W-1:0] w_in,
                                                  logic [SIZE_W-1:0] h_in, logic try_rot);
        placement_t p;
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int s0;
        int s1;
        p = '0;
        w = int'(w_in);
        h = int'(h_in);
        x1 = 0;
        y1 = 0;
        s1 = 0;
        if (op == OP_CLEAR)
        begin
            build_walls();
            return p;
        end
        s0 = best_spot(w, h, x0, y0);
        if (try_rot && w != h)
            s1 = best_spot(h, w, x1, y1);
        if (s0 == 0 && s1 == 0)
            return p;
        if (s1 > s0)
        begin
            p.rotated = 1'b1;
            x0 = x1;
            y0 = y1;
            s0 = s1;
            mark_rect(x0, y0, h, w);
        end
        else
            mark_rect(x0, y0, w, h);
        p.placed = 1'b1;
        p.pos_x = x0[POS_W-1:0];
        p.pos_y = y0[POS_W-1:0];
        p.score = s0[SCORE_W-1:0];
        return p;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        placement_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_placements.size() == 0)
                report("unexpected result item", 1, 0);
            else
            begin
                want = pending_placements.pop_front();
                if (m_tuser !== want.placed)
                    report("placed", m_tuser, want.placed);
                if (m_tdata[5:0] !== want.pos_x)
                    report("pos_x", m_tdata[5:0], want.pos_x);
                if (m_tdata[11:6] !== want.pos_y)
                    report("pos_y", m_tdata[11:6], want.pos_y);
                if (m_tdata[12] !== want.rotated)
                    report("rotated_flag", m_tdata[12], want.rotated);
                if (m_tdata[21:13] !== want.score)
                    report("contact_score", m_tdata[21:13], want.score);
            end
            rx_wait = $urandom_range(0, 3);
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_item(input logic op, input int w, input int h, input logic try_rot);
        int gap;
        placement_t expected;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, try_rot, h[SIZE_W-1:0], w[SIZE_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        expected = best_placement(op, w[SIZE_W-1:0], h[SIZE_W-1:0], try_rot);
        pending_placements.insert(pending_placements.size(), expected);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    task automatic write_canvas(input logic idx, input int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_CANVAS_WIDTH)
            canvas_w_reg = value[CFG_W-1:0];
        else
            canvas_h_reg = value[CFG_W-1:0];
        build_walls();
        repeat (SWEEP_WAIT) @(negedge clk);
    endtask

    task automatic test_full_canvas();
        send_item(OP_PLACE, 64, 64, 1'b0);
        send_item(OP_PLACE, 64, 64, 1'b1);
        send_item(OP_CLEAR, 127, 127, 1'b1);
        send_item(OP_PLACE, 0, 5, 1'b1);
        send_item(OP_PLACE, 5, 0, 1'b0);
        send_item(OP_PLACE, 127, 1, 1'b1);
        send_item(OP_PLACE, 65, 64, 1'b1);
        send_item(OP_PLACE, 64, 32, 1'b1);
        send_item(OP_PLACE, 32, 64, 1'b1);
        send_item(OP_PLACE, 1, 64, 1'b1);
        send_item(OP_PLACE, 63, 31, 1'b0);
        send_item(OP_CLEAR, 0, 0, 1'b0);
        drain();
    endtask

    task automatic test_canvas_limits();
        write_canvas(REG_CANVAS_WIDTH, 0);
        write_canvas(REG_CANVAS_HEIGHT, 127);
        send_item(OP_PLACE, 1, 1, 1'b1);
        send_item(OP_PLACE, 1, 63, 1'b0);
        send_item(OP_PLACE, 2, 1, 1'b1);
        send_item(OP_PLACE, 1, 1, 1'b0);
        drain();
        write_canvas(REG_CANVAS_WIDTH, 127);
        write_canvas(REG_CANVAS_HEIGHT, 0);
        send_item(OP_PLACE, 1, 64, 1'b1);
        send_item(OP_PLACE, 30, 1, 1'b1);
        send_item(OP_PLACE, 34, 1, 1'b0);
        drain();
        write_canvas(REG_CANVAS_WIDTH, 1);
        write_canvas(REG_CANVAS_HEIGHT, 1);
        send_item(OP_PLACE, 1, 1, 1'b1);
        send_item(OP_PLACE, 1, 1, 1'b1);
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        int cw;
        int ch;
        int r;
        for (int p = 0; p < phases; p++)
        begin
            cw = $urandom_range(2, 12);
            ch = $urandom_range(2, 12);
            write_canvas(REG_CANVAS_WIDTH, cw);
            write_canvas(REG_CANVAS_HEIGHT, ch);
            for (int i = 0; i < per_phase; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_item(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                              1'($urandom_range(0, 1)));
                else if (r < 16)
                    send_item(OP_PLACE, $urandom_range(0, 127), $urandom_range(0, 127),
                              1'($urandom_range(0, 1)));
                else
                    send_item(OP_PLACE, $urandom_range(1, cw), $urandom_range(1, ch),
                              1'($urandom_range(0, 1)));
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_canvas(REG_CANVAS_WIDTH, 4);
        write_canvas(REG_CANVAS_HEIGHT, 4);
        rx_hold = 3000;
        for (int i = 0; i < 8; i++)
            send_item(OP_PLACE, $urandom_range(1, 2), $urandom_range(1, 2),
                      1'($urandom_range(0, 1)));
        drain();
        for (int i = 0; i < 4; i++)
            send_item(OP_PLACE, 1, $urandom_range(1, 3), 1'b1);
        drain();
    endtask

    initial
    begin
        build_walls();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_full_canvas();
        test_canvas_limits();
        test_backpressure();
        test_random(4, 20);
        write_canvas(REG_CANVAS_WIDTH, 64);
        write_canvas(REG_CANVAS_HEIGHT, 64);
        send_item(OP_PLACE, 60, 62, 1'b1);
        drain();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
